// ===== rtl/dep_pkg.sv =====
// Shared types and constants for the directory entry parser.
// No dependencies; imported by every module of the block.
package dep_pkg;

  localparam int unsigned HdrBytes = 8;
  localparam logic [7:0]  DotChar  = 8'h2E;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned QueueDepth = 4;
  localparam logic        SkipDotReset = 1'b1;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_END     = 2'd2,
    KIND_CORRUPT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    logic [31:0] entry_inode;
    logic [7:0]  name_length;
    logic        name_last;
  } out_item_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r2;
    out_item_t  r1;
    out_item_t  r0;
  } res_set_t;

endpackage

// ===== rtl/dep_parse.sv =====
// Header/name/padding parser: state registers and the per-byte decode.
// Depends on dep_pkg; produces up to three results per accepted byte.
module dep_parse
  import dep_pkg::*;
#(
  parameter logic SKIP_RESET = SkipDotReset
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t in_data,
  input  logic     cfg_we,
  input  logic     cfg_data,
  output res_set_t res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [31:0] inode_reg, inode_reg_next;
  logic [15:0] record_length, record_length_next;
  logic [7:0]  name_size_reg, name_size_reg_next;
  logic [7:0]  name_index, name_index_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic        held_dot, held_dot_next;
  logic        skip_dot;

  out_item_t   slot [MaxRes];
  logic [1:0]  n;

  function automatic out_item_t mk(kind_t k, logic [7:0] b, logic [31:0] ino,
                                   logic [7:0] nl, logic last);
    out_item_t r;
    r.kind = k;
    r.name_byte = b;
    r.entry_inode = ino;
    r.name_length = nl;
    r.name_last = last;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        final_byte;
    logic [15:0] skip_dec;
    b = in_data.data_byte;
    final_byte = 1'b0;
    skip_dec = 16'd0;
    phase_next = phase;
    header_index_next = header_index;
    inode_reg_next = inode_reg;
    record_length_next = record_length;
    name_size_reg_next = name_size_reg;
    name_index_next = name_index;
    skip_remaining_next = skip_remaining;
    held_dot_next = held_dot;
    n = 2'd0;
    for (int k = 0; k < MaxRes; k++) slot[k] = '0;

    unique case (phase)
      PH_HEADER: begin
        unique case (header_index)
          3'd0: inode_reg_next[7:0]   = b;
          3'd1: inode_reg_next[15:8]  = b;
          3'd2: inode_reg_next[23:16] = b;
          3'd3: inode_reg_next[31:24] = b;
          3'd4: record_length_next[7:0]  = b;
          3'd5: record_length_next[15:8] = b;
          3'd6: name_size_reg_next = b;
          default: ;
        endcase
        if (header_index != 3'd7) begin
          header_index_next = header_index + 3'd1;
        end else begin
          header_index_next = 3'd0;
          if (record_length == 16'd0) begin
            slot[n] = mk(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0);
            n = n + 2'd1;
            phase_next = PH_STOP;
          end else if (record_length < 16'(HdrBytes)) begin
            slot[n] = mk(KIND_CORRUPT, 8'd0, 32'd0, 8'd0, 1'b0);
            n = n + 2'd1;
            phase_next = PH_STOP;
          end else if (inode_reg == 32'd0) begin
            skip_remaining_next = record_length - 16'(HdrBytes);
            phase_next = (skip_remaining_next != 16'd0) ? PH_SKIP : PH_HEADER;
          end else if ({1'b0, record_length} < ({9'd0, name_size_reg} + 17'(HdrBytes))) begin
            slot[n] = mk(KIND_CORRUPT, 8'd0, 32'd0, 8'd0, 1'b0);
            n = n + 2'd1;
            phase_next = PH_STOP;
          end else begin
            skip_remaining_next = record_length - 16'(HdrBytes) - {8'd0, name_size_reg};
            name_index_next = 8'd0;
            held_dot_next = 1'b0;
            if (name_size_reg == 8'd0) begin
              slot[n] = mk(KIND_EMPTY, 8'd0, inode_reg, 8'd0, 1'b1);
              n = n + 2'd1;
              phase_next = (skip_remaining_next != 16'd0) ? PH_SKIP : PH_HEADER;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        final_byte = ({1'b0, name_index} + 9'd1) >= {1'b0, name_size_reg};
        if (skip_dot && b == DotChar && name_index == 8'd0 && name_size_reg <= 8'd2) begin
          // hold a leading dot until the second byte decides
          if (name_size_reg == 8'd2) held_dot_next = 1'b1;
        end else if (held_dot) begin
          held_dot_next = 1'b0;
          if (b != DotChar) begin
            slot[n] = mk(KIND_NAME, DotChar, inode_reg, name_size_reg, 1'b0);
            n = n + 2'd1;
            slot[n] = mk(KIND_NAME, b, inode_reg, name_size_reg, final_byte);
            n = n + 2'd1;
          end
        end else begin
          slot[n] = mk(KIND_NAME, b, inode_reg, name_size_reg, final_byte);
          n = n + 2'd1;
        end
        name_index_next = name_index + 8'd1;
        if (final_byte) begin
          name_index_next = 8'd0;
          held_dot_next = 1'b0;
          phase_next = (skip_remaining != 16'd0) ? PH_SKIP : PH_HEADER;
        end
      end
      PH_SKIP: begin
        skip_dec = (skip_remaining != 16'd0) ? skip_remaining - 16'd1 : skip_remaining;
        skip_remaining_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = PH_HEADER;
      end
      PH_STOP: ;
      default: ;
    endcase

    if (in_data.last_byte) begin
      if (phase_next == PH_NAME) begin
        slot[n] = mk(KIND_CORRUPT, 8'd0, 32'd0, 8'd0, 1'b0);
        n = n + 2'd1;
      end else if (phase_next != PH_STOP) begin
        slot[n] = mk(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0);
        n = n + 2'd1;
      end
      // restart at a header
      phase_next = PH_HEADER;
      header_index_next = 3'd0;
      inode_reg_next = 32'd0;
      record_length_next = 16'd0;
      name_size_reg_next = 8'd0;
      name_index_next = 8'd0;
      skip_remaining_next = 16'd0;
      held_dot_next = 1'b0;
    end
  end

  always_comb begin
    res.count = accept ? n : 2'd0;
    res.r0 = slot[0];
    res.r1 = slot[1];
    res.r2 = slot[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_index <= 3'd0;
      inode_reg <= 32'd0;
      record_length <= 16'd0;
      name_size_reg <= 8'd0;
      name_index <= 8'd0;
      skip_remaining <= 16'd0;
      held_dot <= 1'b0;
      skip_dot <= SKIP_RESET;
    end else begin
      if (accept) begin
        phase <= phase_next;
        header_index <= header_index_next;
        inode_reg <= inode_reg_next;
        record_length <= record_length_next;
        name_size_reg <= name_size_reg_next;
        name_index <= name_index_next;
        skip_remaining <= skip_remaining_next;
        held_dot <= held_dot_next;
      end
      if (cfg_we) skip_dot <= cfg_data;
    end
  end

endmodule

// ===== rtl/dep_outq.sv =====
// Result queue: shift-style buffer of QueueDepth results, up to three pushed per cycle.
// Depends on dep_pkg; head slot drives the output request.
module dep_outq
  import dep_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  res_set_t  push,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  q [QueueDepth];
  out_item_t  q_next [QueueDepth];
  logic [2:0] count, count_next;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_data  = q[0];
  assign pop       = out_valid && out_ready;
  // room for a full burst of results
  assign space     = (count <= 3'd1);

  always_comb begin
    out_item_t  shifted [QueueDepth];
    out_item_t  pick;
    logic [2:0] base;
    logic [2:0] off;
    base = count - {2'd0, pop};
    for (int k = 0; k < QueueDepth; k++) begin
      shifted[k] = (pop && k < QueueDepth - 1) ? q[(k + 1) % QueueDepth] : q[k];
    end
    for (int k = 0; k < QueueDepth; k++) begin
      off = 3'(k) - base;
      case (off[1:0])
        2'd0:    pick = push.r0;
        2'd1:    pick = push.r1;
        default: pick = push.r2;
      endcase
      if (3'(k) >= base && off < {1'b0, push.count}) begin
        q_next[k] = pick;
      end else begin
        q_next[k] = shifted[k];
      end
    end
    count_next = base + {1'b0, push.count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QueueDepth; k++) q[k] <= q_next[k];
  end

endmodule

// ===== rtl/directory_entry_parser_core.sv =====
// Channel  | dir | handshake            | payload
// in       | in  | in_valid / in_ready  | in_data  (data_byte, last_byte)
// out      | out | out_valid / out_ready| out_data (kind, name_byte, entry_inode,
//          |     |                      |           name_length, name_last)
// cfg      | in  | cfg_valid / cfg_ready| cfg_data (skip_dot_entries)
//
// One byte is accepted per cycle while in_ready is high; its results (zero to three)
// land in a four-entry result queue in the same edge and leave one per cycle while
// out_ready is high. in_ready is high while the queue holds at most one result.
// Reset (synchronous) empties the queue, returns the parser to a header and sets
// skip_dot_entries to SKIP_RESET. cfg_ready is always high.
// Depends on dep_pkg, dep_parse and dep_outq.
module directory_entry_parser_core
  import dep_pkg::*;
#(
  parameter logic SKIP_RESET = SkipDotReset
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  res_set_t res;
  logic     space;
  logic     accept;

  assign in_ready  = space;
  assign accept    = in_valid && space;
  assign cfg_ready = 1'b1;

  dep_parse #(
    .SKIP_RESET(SKIP_RESET)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .cfg_we  (cfg_valid),
    .cfg_data(cfg_data),
    .res     (res)
  );

  dep_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
